// ----- rtl/two_port_learning_bridge_assert.svh -----
// Assertion helpers used by the checker file of the bridge.
`ifndef TWO_PORT_LEARNING_BRIDGE_ASSERT_SVH
`define TWO_PORT_LEARNING_BRIDGE_ASSERT_SVH

// Check an implication in the same cycle, clocked on clk, off during reset.
`define TPLB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, clocked on clk, off during reset.
`define TPLB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tplb_pkg.sv -----
`timescale 1ns / 1ps

package tplb_pkg;

    localparam int MAC_W      = 48;
    localparam int KIND_W     = 16;
    localparam int TOP_W      = 8;
    localparam int CFG_IDX_W  = 3;

    localparam logic [KIND_W-1:0] KIND_IPV4 = 16'h0800;

    // Martian destination top bytes
    localparam logic [TOP_W-1:0] MARTIAN_THIS_NET  = 8'd0;
    localparam logic [TOP_W-1:0] MARTIAN_LOOPBACK  = 8'd127;
    localparam logic [TOP_W-1:0] MARTIAN_BROADCAST = 8'd255;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC_B     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REWRITE_TO_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REWRITE_TO_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_MARTIANS = 3'd4;

    localparam logic PORT_A = 1'b0;
    localparam logic PORT_B = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_FORWARD  = 2'd0,
        VERDICT_OWN_PORT = 2'd1,
        VERDICT_MISMATCH = 2'd2,
        VERDICT_MARTIAN  = 2'd3
    } verdict_t;

    // Search token that steps along the table cells
    typedef struct packed {
        logic             active;
        logic             skip;
        logic [MAC_W-1:0] key;
        logic             port;
        logic             hit;
        logic             hit_port;
        logic             learned;
    } token_t;

    // Frame fields held while its search runs
    typedef struct packed {
        logic [MAC_W-1:0]  dest_mac;
        logic              port;
        logic [KIND_W-1:0] kind;
        logic [TOP_W-1:0]  top;
        logic              own;
    } ctx_t;

    typedef struct packed {
        logic [MAC_W-1:0] own_a;
        logic [MAC_W-1:0] own_b;
        logic [MAC_W-1:0] rewrite_a;
        logic [MAC_W-1:0] rewrite_b;
        logic             drop_martians;
    } cfg_t;

    typedef struct packed {
        logic             forward;
        logic             exit_port;
        logic [MAC_W-1:0] new_dest_mac;
        verdict_t         verdict;
        logic             learned_now;
        logic             table_full;
    } result_t;

endpackage

// ----- rtl/tplb_if.sv -----
`timescale 1ns / 1ps

// Frame header request channel
interface tplb_frame_if;
    logic                          valid;
    logic                          ready;
    logic [tplb_pkg::MAC_W-1:0]    source_mac;
    logic [tplb_pkg::MAC_W-1:0]    dest_mac;
    logic                          arrival_port;
    logic [tplb_pkg::KIND_W-1:0]   ether_kind;
    logic [tplb_pkg::TOP_W-1:0]    dest_ip_top_byte;

    modport source (output valid, source_mac, dest_mac, arrival_port, ether_kind,
                    dest_ip_top_byte, input ready);
    modport sink (input valid, source_mac, dest_mac, arrival_port, ether_kind,
                  dest_ip_top_byte, output ready);
endinterface

// Result request channel
interface tplb_result_if;
    logic                          valid;
    logic                          ready;
    logic                          forward;
    logic                          exit_port;
    logic [tplb_pkg::MAC_W-1:0]    new_dest_mac;
    logic [1:0]                    verdict;
    logic                          learned_now;
    logic                          table_full;

    modport source (output valid, forward, exit_port, new_dest_mac, verdict,
                    learned_now, table_full, input ready);
    modport sink (input valid, forward, exit_port, new_dest_mac, verdict,
                  learned_now, table_full, output ready);
endinterface

// Configuration write channel
interface tplb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tplb_pkg::CFG_IDX_W-1:0]  index;
    logic [tplb_pkg::MAC_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/two_port_learning_bridge.sv -----
`timescale 1ns / 1ps

// Two-port learning bridge. One frame header is taken at a time: a search token
// walks the row of TABLE_ENTRIES table cells, one cell per clock, comparing the
// source MAC and learning it in the lowest free cell. The verdict is registered
// in the pending result register and then moved to the output register, which
// drives the result port; the next header can be taken once the result has
// moved on to the output register. A stalled result port therefore does not hold
// up the next header, but while a finished result waits for the output register
// the bridge stays busy. Table valid marks clear at reset with no clearing pass;
// entries are never aged. Configuration writes are always accepted and should
// be made while no header is in flight.
module two_port_learning_bridge #(
    parameter int TABLE_ENTRIES = 64
) (
    input logic             clk,
    input logic             rst_n,
    tplb_frame_if.sink      frame_in,
    tplb_result_if.source   result_out,
    tplb_cfg_if.sink        cfg
);
    import tplb_pkg::*;

    cfg_t    cfg_reg;
    ctx_t    ctx_reg;
    logic    busy_reg;
    logic    pend_valid_reg;
    result_t pend_reg;
    logic    out_valid_reg;
    result_t out_reg;
    token_t  tok [0:TABLE_ENTRIES];
    token_t  tok_first;
    result_t res;
    logic    accept;
    logic    own_src;
    logic    pend_move;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_OWN_MAC_A:     cfg_reg.own_a         <= cfg.data;
                REG_OWN_MAC_B:     cfg_reg.own_b         <= cfg.data;
                REG_REWRITE_TO_A:  cfg_reg.rewrite_a     <= cfg.data;
                REG_REWRITE_TO_B:  cfg_reg.rewrite_b     <= cfg.data;
                REG_DROP_MARTIANS: cfg_reg.drop_martians <= cfg.data[0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Accept a header and launch its token into the first cell
    assign frame_in.ready = !busy_reg;
    assign accept         = frame_in.valid && !busy_reg;
    assign own_src        = (frame_in.source_mac == cfg_reg.own_a)
                         || (frame_in.source_mac == cfg_reg.own_b);

    always_comb
    begin
        tok_first        = '0;
        tok_first.active = accept;
        tok_first.skip   = own_src;
        tok_first.key    = frame_in.source_mac;
        tok_first.port   = frame_in.arrival_port;
    end

    assign tok[0] = tok_first;

    // Hold the frame fields for the decision at the end of the row
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctx_reg.dest_mac <= frame_in.dest_mac;
            ctx_reg.port     <= frame_in.arrival_port;
            ctx_reg.kind     <= frame_in.ether_kind;
            ctx_reg.top      <= frame_in.dest_ip_top_byte;
            ctx_reg.own      <= own_src;
        end
    end

    // Row of table cells
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        tplb_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    tplb_decide u_decide (
        .ctx (ctx_reg),
        .cfg (cfg_reg),
        .tok (tok[TABLE_ENTRIES]),
        .res (res)
    );

    // Busy from accept until the result moves to the output register
    assign pend_move = pend_valid_reg && (!out_valid_reg || result_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                busy_reg <= 1'b0;
            end

            if (tok[TABLE_ENTRIES].active)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (pend_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        if (tok[TABLE_ENTRIES].active)
        begin
            pend_reg <= res;
        end
        if (pend_move)
        begin
            out_reg <= pend_reg;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.forward      = out_reg.forward;
    assign result_out.exit_port    = out_reg.exit_port;
    assign result_out.new_dest_mac = out_reg.new_dest_mac;
    assign result_out.verdict      = out_reg.verdict;
    assign result_out.learned_now  = out_reg.learned_now;
    assign result_out.table_full   = out_reg.table_full;

endmodule

// ----- rtl/tplb_cell.sv -----
`timescale 1ns / 1ps

module tplb_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  tplb_pkg::token_t tok_in,
    output tplb_pkg::token_t tok_out
);
    import tplb_pkg::*;

    logic             valid_reg;
    logic [MAC_W-1:0] mac_reg;
    logic             port_reg;
    token_t           tok_reg;
    token_t           tok_next;
    logic             write_en;

    // Compare against the held entry, or claim it when it is the first free one
    always_comb
    begin
        tok_next = tok_in;
        write_en = 1'b0;
        if (tok_in.active && !tok_in.skip && !tok_in.hit)
        begin
            if (valid_reg)
            begin
                if (mac_reg == tok_in.key)
                begin
                    tok_next.hit      = 1'b1;
                    tok_next.hit_port = port_reg;
                end
            end
            else if (!tok_in.learned)
            begin
                tok_next.learned = 1'b1;
                write_en         = 1'b1;
            end
        end
    end

    // Hold the entry valid mark; cleared only by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (write_en)
        begin
            valid_reg <= 1'b1;
        end
    end

    // Learn the entry payload
    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            mac_reg  <= tok_in.key;
            port_reg <= tok_in.port;
        end
    end

    // Advance the token to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/tplb_decide.sv -----
`timescale 1ns / 1ps

module tplb_decide (
    input  tplb_pkg::ctx_t    ctx,
    input  tplb_pkg::cfg_t    cfg,
    input  tplb_pkg::token_t  tok,
    output tplb_pkg::result_t res
);
    import tplb_pkg::*;

    logic             martian_top;
    logic [MAC_W-1:0] rewrite_mac;

    assign martian_top = (ctx.top == MARTIAN_THIS_NET) || (ctx.top == MARTIAN_LOOPBACK)
                      || (ctx.top == MARTIAN_BROADCAST);
    assign rewrite_mac = (ctx.port == PORT_A) ? cfg.rewrite_b : cfg.rewrite_a;

    // Settle the verdict from the search outcome and the frame fields
    always_comb
    begin
        res              = '0;
        res.new_dest_mac = ctx.dest_mac;
        res.verdict      = VERDICT_FORWARD;
        if (ctx.own)
        begin
            res.verdict = VERDICT_OWN_PORT;
        end
        else
        begin
            res.learned_now = tok.learned;
            res.table_full  = !tok.hit && !tok.learned;
            if (tok.hit && (tok.hit_port != ctx.port))
            begin
                res.verdict = VERDICT_MISMATCH;
            end
            else if (cfg.drop_martians && (ctx.kind == KIND_IPV4) && martian_top)
            begin
                res.verdict = VERDICT_MARTIAN;
            end
            else
            begin
                res.forward   = 1'b1;
                res.exit_port = ~ctx.port;
                if (rewrite_mac != '0)
                begin
                    res.new_dest_mac = rewrite_mac;
                end
            end
        end
    end

endmodule

// ----- rtl/tplb_checker.sv -----
`timescale 1ns / 1ps
`include "two_port_learning_bridge_assert.svh"

module tplb_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       out_forward,
    input logic                       out_exit_port,
    input logic [tplb_pkg::MAC_W-1:0] out_new_dest_mac,
    input logic [1:0]                 out_verdict,
    input logic                       out_learned_now,
    input logic                       out_table_full
);
    import tplb_pkg::*;

    // A stalled result holds its payload
    `TPLB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_verdict) && $stable(out_new_dest_mac), "result changed while stalled")

    // One header at a time: no request taken in the cycle after an accept
    `TPLB_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "header taken while busy")

    // Forward flag agrees with the verdict, and drops leave on port A
    `TPLB_ASSERT_NOW(a_fwd_verdict, out_valid, (out_forward == (out_verdict == VERDICT_FORWARD)) && (out_forward || !out_exit_port), "forward and verdict disagree")

    // Own-port drops skip the table; learning and a full table exclude each other
    `TPLB_ASSERT_NOW(a_learn_flags, out_valid, !(out_learned_now && out_table_full) && ((out_verdict != VERDICT_OWN_PORT) || (!out_learned_now && !out_table_full)), "bad learning flags")

endmodule

bind two_port_learning_bridge tplb_checker u_tplb_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (frame_in.valid),
    .in_ready         (frame_in.ready),
    .out_valid        (result_out.valid),
    .out_ready        (result_out.ready),
    .out_forward      (result_out.forward),
    .out_exit_port    (result_out.exit_port),
    .out_new_dest_mac (result_out.new_dest_mac),
    .out_verdict      (result_out.verdict),
    .out_learned_now  (result_out.learned_now),
    .out_table_full   (result_out.table_full)
);

// ----- tb/two_port_learning_bridge_test.sv -----
`timescale 1ns / 1ps

module two_port_learning_bridge_test;

    import tplb_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_FRAMES  = 180;

    localparam logic [MAC_W-1:0] MAC_ZERO = '0;
    localparam logic [MAC_W-1:0] MAC_ONES = '1;

    // Index beyond the register list; a write to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [MAC_W-1:0]  source_mac;
        logic [MAC_W-1:0]  dest_mac;
        logic              arrival_port;
        logic [KIND_W-1:0] ether_kind;
        logic [TOP_W-1:0]  dest_ip_top_byte;
    } frame_t;

    logic clk = 1'b0;
    logic rst_n;

    tplb_frame_if  frame_bus ();
    tplb_result_if result_bus ();
    tplb_cfg_if    cfg_bus ();

    // Bridge model state: learned table fills from the lowest slot, never shrinks
    cfg_t             cfg_copy;
    logic [MAC_W-1:0] table_mac [TABLE_ENTRIES];
    logic             table_port [TABLE_ENTRIES];
    int               learned_count;

    result_t expected_results [$];
    int      mismatches;
    int      results_seen;
    bit      idle_on;
    int      sink_hold;

    two_port_learning_bridge #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .frame_in(frame_bus),
        .result_out(result_bus),
        .cfg(cfg_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Work out the bridge decision for one frame and update the learned table
    function automatic result_t bridge_decide(input frame_t f);
        result_t r;
        int      hit;
        logic    is_martian;
        logic [MAC_W-1:0] rewrite;
        r.forward      = 1'b0;
        r.exit_port    = PORT_A;
        r.new_dest_mac = f.dest_mac;
        r.verdict      = VERDICT_FORWARD;
        r.learned_now  = 1'b0;
        r.table_full   = 1'b0;
        if (f.source_mac == cfg_copy.own_a || f.source_mac == cfg_copy.own_b)
        begin
            r.verdict = VERDICT_OWN_PORT;
            return r;
        end
        hit = -1;
        for (int i = 0; i < learned_count; i++)
        begin
            if (hit < 0 && table_mac[i] == f.source_mac)
                hit = i;
        end
        if (hit < 0)
        begin
            if (learned_count < TABLE_ENTRIES)
            begin
                table_mac[learned_count]  = f.source_mac;
                table_port[learned_count] = f.arrival_port;
                learned_count++;
                r.learned_now = 1'b1;
            end
            else
                r.table_full = 1'b1;
        end
        is_martian = cfg_copy.drop_martians && f.ether_kind == KIND_IPV4 &&
                     (f.dest_ip_top_byte == MARTIAN_THIS_NET ||
                      f.dest_ip_top_byte == MARTIAN_LOOPBACK ||
                      f.dest_ip_top_byte == MARTIAN_BROADCAST);
        if (hit >= 0 && table_port[hit] != f.arrival_port)
            r.verdict = VERDICT_MISMATCH;
        else if (is_martian)
            r.verdict = VERDICT_MARTIAN;
        else
        begin
            r.forward   = 1'b1;
            r.exit_port = ~f.arrival_port;
            rewrite     = (r.exit_port == PORT_B) ? cfg_copy.rewrite_b : cfg_copy.rewrite_a;
            if (rewrite != MAC_ZERO)
                r.new_dest_mac = rewrite;
        end
        return r;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 12);
        return $urandom_range(30, 100);
    endfunction

    function automatic int pick_send_gap();
        if (!idle_on || $urandom_range(0, 1) == 0)
            return 0;
        return pick_gap();
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] result %0d: %s got %h want %h", $realtime, results_seen, what,
                 got, want);
        mismatches++;
    endtask

    // Offer one frame request and predict its result once it is taken
    task automatic send_frame(input frame_t f);
        int gap;
        gap = pick_send_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            frame_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        frame_bus.valid            <= 1'b1;
        frame_bus.source_mac       <= f.source_mac;
        frame_bus.dest_mac         <= f.dest_mac;
        frame_bus.arrival_port     <= f.arrival_port;
        frame_bus.ether_kind       <= f.ether_kind;
        frame_bus.dest_ip_top_byte <= f.dest_ip_top_byte;
        do
            @(posedge clk);
        while (!frame_bus.ready);
        expected_results.push_back(bridge_decide(f));
    endtask

    task automatic send_fields(input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst,
                               input logic port, input logic [KIND_W-1:0] kind,
                               input logic [TOP_W-1:0] top);
        frame_t f;
        f = '{src, dst, port, kind, top};
        send_frame(f);
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic drain();
        @(negedge clk);
        frame_bus.valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAC_W-1:0] data);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            REG_OWN_MAC_A:     cfg_copy.own_a = data;
            REG_OWN_MAC_B:     cfg_copy.own_b = data;
            REG_REWRITE_TO_A:  cfg_copy.rewrite_a = data;
            REG_REWRITE_TO_B:  cfg_copy.rewrite_b = data;
            REG_DROP_MARTIANS: cfg_copy.drop_martians = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Registers at reset: zero source is own-port, no rewrite, no martian filter
    task automatic check_reset_defaults();
        idle_on = 1'b0;
        send_fields(MAC_ZERO, MAC_ONES, PORT_A, KIND_IPV4, MARTIAN_THIS_NET);
        send_fields(48'h0200_0000_0001, 48'h1234_5678_9abc, PORT_A, KIND_IPV4,
                    MARTIAN_THIS_NET);
        send_fields(48'h0200_0000_0001, MAC_ZERO, PORT_A, 16'hffff, 8'hff);
        send_fields(48'h0200_0000_0001, MAC_ONES, PORT_B, KIND_IPV4, 8'd10);
        send_fields(MAC_ONES, MAC_ZERO, PORT_B, 16'h0000, MARTIAN_BROADCAST);
        drain();
    endtask

    // Extreme register values, martian filter on, rewrite towards both ports
    task automatic check_config_extremes();
        write_reg(REG_OWN_MAC_A, MAC_ONES);
        write_reg(REG_OWN_MAC_B, 48'h5a5a_5a5a_5a5a);
        write_reg(REG_REWRITE_TO_A, MAC_ONES);
        write_reg(REG_REWRITE_TO_B, 48'h0000_0000_0001);
        write_reg(REG_DROP_MARTIANS, 48'h0000_0000_0001);
        send_fields(MAC_ONES, MAC_ZERO, PORT_A, KIND_IPV4, 8'd1);
        send_fields(48'h5a5a_5a5a_5a5a, MAC_ONES, PORT_B, KIND_IPV4, 8'd1);
        // Martians still learn before they are dropped
        send_fields(MAC_ZERO, MAC_ONES, PORT_A, KIND_IPV4, MARTIAN_THIS_NET);
        send_fields(MAC_ZERO, MAC_ZERO, PORT_A, KIND_IPV4, MARTIAN_LOOPBACK);
        send_fields(MAC_ZERO, MAC_ONES, PORT_A, KIND_IPV4, MARTIAN_BROADCAST);
        // Non-IPv4 is never a martian
        send_fields(MAC_ZERO, MAC_ONES, PORT_A, 16'h0801, MARTIAN_LOOPBACK);
        send_fields(48'ha5a5_a5a5_a5a5, MAC_ZERO, PORT_B, KIND_IPV4, 8'd128);
        send_fields(48'ha5a5_a5a5_a5a5, MAC_ONES, PORT_B, KIND_IPV4, 8'd126);
        send_fields(48'ha5a5_a5a5_a5a5, MAC_ZERO, PORT_B, KIND_IPV4, 8'd254);
        // Port mismatch wins over the martian filter
        send_fields(48'ha5a5_a5a5_a5a5, MAC_ONES, PORT_A, KIND_IPV4, MARTIAN_THIS_NET);
        send_fields(48'h0200_0000_0001, MAC_ZERO, PORT_A, 16'hffff, 8'd0);
        drain();
    endtask

    function automatic logic [MAC_W-1:0] pick_cfg_mac();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return MAC_ZERO;
        if (r == 1)
            return MAC_ONES;
        if (r < 4 && learned_count > 0)
            return table_mac[$urandom_range(0, learned_count - 1)];
        return random_mac();
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        int     r;
        int     slot;
        r = $urandom_range(0, 99);
        f.arrival_port = 1'($urandom_range(0, 1));
        if (r < 12 || learned_count == 0)
            f.source_mac = random_mac();
        else if (r < 18)
            f.source_mac = $urandom_range(0, 1) ? cfg_copy.own_a : cfg_copy.own_b;
        else
        begin
            // Known source, mostly on the port it was learned on
            slot = $urandom_range(0, learned_count - 1);
            f.source_mac   = table_mac[slot];
            f.arrival_port = table_port[slot] ^ ($urandom_range(0, 3) == 0);
        end
        r = $urandom_range(0, 19);
        f.dest_mac = (r == 0) ? MAC_ZERO : (r == 1) ? MAC_ONES : random_mac();
        f.ether_kind = ($urandom_range(0, 99) < 45) ? KIND_IPV4 : 16'($urandom);
        case ($urandom_range(0, 9))
            0:       f.dest_ip_top_byte = MARTIAN_THIS_NET;
            1:       f.dest_ip_top_byte = MARTIAN_LOOPBACK;
            2:       f.dest_ip_top_byte = MARTIAN_BROADCAST;
            3:       f.dest_ip_top_byte = MARTIAN_LOOPBACK + 8'($urandom_range(0, 1) ? 1 : -1);
            default: f.dest_ip_top_byte = 8'($urandom);
        endcase
        return f;
    endfunction

    // Phases of random traffic, each under its own register setting
    task automatic run_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                write_reg(REG_OWN_MAC_A, MAC_ONES);
                write_reg(REG_OWN_MAC_B, MAC_ONES);
                write_reg(REG_REWRITE_TO_A, MAC_ONES);
                write_reg(REG_REWRITE_TO_B, MAC_ONES);
                write_reg(REG_DROP_MARTIANS, MAC_ONES);
            end
            else
            begin
                write_reg(REG_OWN_MAC_A, pick_cfg_mac());
                write_reg(REG_OWN_MAC_B, pick_cfg_mac());
                write_reg(REG_REWRITE_TO_A, pick_cfg_mac());
                write_reg(REG_REWRITE_TO_B, pick_cfg_mac());
                write_reg(REG_DROP_MARTIANS, random_mac());
            end
            if (phase == 2)
                write_reg(REG_UNUSED, random_mac());
            idle_on = (phase % 3 != 1);
            repeat (PHASE_FRAMES) send_frame(random_frame());
            drain();
        end
    endtask

    // Fill the table with fresh sources, then push a few more past the end
    task automatic check_table_full();
        frame_t f;
        int     extra;
        idle_on = 1'b1;
        extra = 0;
        while (learned_count < TABLE_ENTRIES || extra < 4)
        begin
            f = random_frame();
            f.source_mac = random_mac();
            if (learned_count == TABLE_ENTRIES)
                extra++;
            send_frame(f);
        end
    endtask

    // Result sink: hold ready low for random stretches
    initial
    begin
        result_bus.ready = 1'b0;
        sink_hold = 0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                sink_hold--;
                result_bus.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                sink_hold = pick_gap() - 1;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    // Compare each result request with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected", 64'(result_bus.new_dest_mac),
                                64'd0);
            else
            begin
                want = expected_results.pop_front();
                if (result_bus.forward !== want.forward)
                    report_mismatch("forward", 64'(result_bus.forward), 64'(want.forward));
                if (result_bus.exit_port !== want.exit_port)
                    report_mismatch("exit_port", 64'(result_bus.exit_port),
                                    64'(want.exit_port));
                if (result_bus.new_dest_mac !== want.new_dest_mac)
                    report_mismatch("new_dest_mac", 64'(result_bus.new_dest_mac),
                                    64'(want.new_dest_mac));
                if (result_bus.verdict !== want.verdict)
                    report_mismatch("verdict", 64'(result_bus.verdict), 64'(want.verdict));
                if (result_bus.learned_now !== want.learned_now)
                    report_mismatch("learned_now", 64'(result_bus.learned_now),
                                    64'(want.learned_now));
                if (result_bus.table_full !== want.table_full)
                    report_mismatch("table_full", 64'(result_bus.table_full),
                                    64'(want.table_full));
            end
        end
    end

    initial
    begin
        #(10_000_000);
        $display("two_port_learning_bridge_test: FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        frame_bus.valid            = 1'b0;
        frame_bus.source_mac       = '0;
        frame_bus.dest_mac         = '0;
        frame_bus.arrival_port     = PORT_A;
        frame_bus.ether_kind       = '0;
        frame_bus.dest_ip_top_byte = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_OWN_MAC_A;
        cfg_bus.data  = '0;
        cfg_copy      = '0;
        learned_count = 0;
        mismatches    = 0;
        results_seen  = 0;
        idle_on       = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_reset_defaults();
        check_config_extremes();
        run_random_traffic();
        check_table_full();

        // Let the last requests drain, then give the block time to settle
        @(negedge clk);
        frame_bus.valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (TABLE_ENTRIES + 8) @(posedge clk);
        if (mismatches == 0)
            $display("two_port_learning_bridge_test: PASS");
        else
            $display("two_port_learning_bridge_test: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/tplb_pkg.sv
rtl/tplb_if.sv
rtl/tplb_cell.sv
rtl/tplb_decide.sv
rtl/two_port_learning_bridge.sv
rtl/tplb_checker.sv
tb/two_port_learning_bridge_test.sv
